// ===== sv/task_heartbeat_watchdog_supervisor_defines.svh =====
// assertion macros shared by the checker
`ifndef TASK_HEARTBEAT_WATCHDOG_SUPERVISOR_DEFINES_SVH
`define TASK_HEARTBEAT_WATCHDOG_SUPERVISOR_DEFINES_SVH

// same-cycle implication, off during reset
`define THWS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("thws check failed");

// next-cycle implication, off during reset
`define THWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("thws check failed");

// next-cycle implication, always on
`define THWS_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("thws check failed");

`endif

// ===== sv/thws_pkg.sv =====
`default_nettype none
package thws_pkg;

  localparam logic [1:0] OP_BOOT = 2'd0;
  localparam logic [1:0] OP_BEAT = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] REG_GRACE_TICKS  = 2'd0;
  localparam logic [1:0] REG_CHECK_PERIOD = 2'd1;
  localparam logic [1:0] REG_STABLE_CHECKS = 2'd2;
  localparam logic [1:0] REG_WARN_BOOT    = 2'd3;

  localparam logic [7:0]  GRACE_RESET  = 8'd30;
  localparam logic [7:0]  PERIOD_RESET = 8'd5;
  localparam logic [15:0] STABLE_RESET = 16'd60;
  localparam logic [15:0] WARN_RESET   = 16'd5;

  localparam logic [15:0] MAGIC_HI  = 16'hB007;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 56;
  localparam int PADDR_W   = 4;

  typedef struct packed {
    logic [7:0]  grace_ticks;
    logic [7:0]  check_period_ticks;
    logic [15:0] stable_checks;
    logic [15:0] warn_boot_count;
  } cfg_t;

  typedef struct packed {
    logic [31:0] backup_word;
    logic [4:0]  task_id;
    logic [1:0]  operation;
  } item_t;

  typedef struct packed {
    logic        tasks_ok;
    logic        check_done;
    logic        repeated_reset;
    logic [15:0] boot_count;
    logic [31:0] backup_value;
    logic        backup_write;
    logic        refresh;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/task_heartbeat_watchdog_supervisor.sv =====
// Task heartbeat watchdog supervisor.
// Input stream (s_*): one transaction per event. s_tuser holds the operation
// (boot, heartbeat, tick); s_tdata holds task_id and the retained backup word.
// Output stream (m_*): exactly one result transaction per input transaction,
// in order, carrying refresh, backup write request and value, cached boot
// count, repeated-reset flag and the outcome of a completed heartbeat check.
// Configuration: APB port with four registers (grace ticks, check period,
// stable checks, warn boot count); pready is always high.
// Timing: an input transaction is captured in the input register, processed
// against the supervisor state and lands in the output register, which
// drives m_tvalid. Throughput is one transaction per cycle while m_tready
// stays high, set by the combinational state update between the input and
// output registers.
// When m_tready is low the output register holds its result and the input
// register still takes one more transaction; further input waits.
// Reset (rst, synchronous) restores register defaults, starts the grace
// phase, clears heartbeat flags and counters and empties both registers.
`default_nettype none
module task_heartbeat_watchdog_supervisor
  import thws_pkg::*;
#(
  parameter int TASKS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // [4:0] task_id, [36:5] backup_word, zero pad above
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // [1:0] operation
  input  wire logic [S_TUSER_W-1:0] s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [0] refresh, [1] backup_write, [33:2] backup_value, [49:34] boot_count,
  // [50] repeated_reset, [51] check_done, [52] tasks_ok, zero pad above
  output logic [M_TDATA_W-1:0]      m_tdata,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  cfg_t  cfg;
  item_t in_item;
  logic  in_valid;
  logic  step;
  res_t  res;
  res_t  out_res;

  assign pready   = 1'b1;
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  thws_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.operation   <= s_tuser[1:0];
      in_item.task_id     <= s_tdata[4:0];
      in_item.backup_word <= s_tdata[36:5];
    end
  end

  thws_core #(
    .TASKS (TASKS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_res <= res;
  end

  assign m_tdata = {{(M_TDATA_W - $bits(res_t)){1'b0}}, out_res};

endmodule
`default_nettype wire

// ===== sv/thws_cfg_regs.sv =====
`default_nettype none
module thws_cfg_regs
  import thws_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output cfg_t                    cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grace_ticks        <= GRACE_RESET;
      cfg.check_period_ticks <= PERIOD_RESET;
      cfg.stable_checks      <= STABLE_RESET;
      cfg.warn_boot_count    <= WARN_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_GRACE_TICKS:   cfg.grace_ticks        <= pwdata[7:0];
        REG_CHECK_PERIOD:  cfg.check_period_ticks <= pwdata[7:0];
        REG_STABLE_CHECKS: cfg.stable_checks      <= pwdata[15:0];
        REG_WARN_BOOT:     cfg.warn_boot_count    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_GRACE_TICKS:   prdata = {24'd0, cfg.grace_ticks};
      REG_CHECK_PERIOD:  prdata = {24'd0, cfg.check_period_ticks};
      REG_STABLE_CHECKS: prdata = {16'd0, cfg.stable_checks};
      REG_WARN_BOOT:     prdata = {16'd0, cfg.warn_boot_count};
      default:           prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/thws_core.sv =====
`default_nettype none
module thws_core
  import thws_pkg::*;
#(
  parameter int TASKS = 8
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  step,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output res_t       res
);

  logic [TASKS-1:0] seen_flags, seen_flags_next;
  logic             in_grace, in_grace_next;
  logic [7:0]       tick_count, tick_count_next;
  logic [15:0]      stable_count, stable_count_next;
  logic             boot_cleared, boot_cleared_next;
  logic [15:0]      cached_boot_count, cached_boot_count_next;

  logic [15:0] boot_cnt;
  logic [7:0]  tick_inc;
  logic [15:0] stable_inc;
  logic        alive;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_flags        <= '0;
      in_grace          <= 1'b1;
      tick_count        <= 8'd0;
      stable_count      <= 16'd0;
      boot_cleared      <= 1'b0;
      cached_boot_count <= 16'd0;
    end else if (step) begin
      seen_flags        <= seen_flags_next;
      in_grace          <= in_grace_next;
      tick_count        <= tick_count_next;
      stable_count      <= stable_count_next;
      boot_cleared      <= boot_cleared_next;
      cached_boot_count <= cached_boot_count_next;
    end
  end

  always_comb begin
    if (item.backup_word[31:16] == MAGIC_HI) begin
      boot_cnt = (item.backup_word[15:0] == COUNT_MAX) ? COUNT_MAX
                                                       : item.backup_word[15:0] + 16'd1;
    end else begin
      boot_cnt = 16'd1;
    end
    tick_inc   = tick_count + 8'd1;
    stable_inc = (stable_count == COUNT_MAX) ? stable_count : stable_count + 16'd1;
    alive      = &seen_flags;
  end

  always_comb begin
    seen_flags_next        = seen_flags;
    in_grace_next          = in_grace;
    tick_count_next        = tick_count;
    stable_count_next      = stable_count;
    boot_cleared_next      = boot_cleared;
    cached_boot_count_next = cached_boot_count;
    res                    = '0;

    case (item.operation)
      OP_BOOT: begin
        res.backup_write       = 1'b1;
        res.backup_value       = {MAGIC_HI, boot_cnt};
        cached_boot_count_next = boot_cnt;
        in_grace_next          = 1'b1;
        tick_count_next        = 8'd0;
        seen_flags_next        = '0;
        stable_count_next      = 16'd0;
        boot_cleared_next      = 1'b0;
      end
      OP_BEAT: begin
        for (int i = 0; i < TASKS; i++) begin
          if (item.task_id == 5'(i)) seen_flags_next[i] = 1'b1;
        end
      end
      OP_TICK: begin
        tick_count_next = tick_inc;
        if (in_grace) begin
          res.refresh = 1'b1;
          if (tick_inc >= cfg.grace_ticks) begin
            in_grace_next   = 1'b0;
            tick_count_next = 8'd0;
            seen_flags_next = '0;
          end
        end else if (tick_inc >= cfg.check_period_ticks) begin
          tick_count_next = 8'd0;
          res.check_done  = 1'b1;
          res.tasks_ok    = alive;
          seen_flags_next = '0;
          if (alive) begin
            res.refresh = 1'b1;
            if (!boot_cleared) begin
              stable_count_next = stable_inc;
              if (stable_inc >= cfg.stable_checks) begin
                res.backup_write  = 1'b1;
                res.backup_value  = {MAGIC_HI, 16'd0};
                boot_cleared_next = 1'b1;
              end
            end
          end else begin
            stable_count_next = 16'd0;
          end
        end
      end
      default: ;
    endcase

    res.boot_count     = cached_boot_count_next;
    res.repeated_reset = (cached_boot_count_next >= cfg.warn_boot_count);
  end

endmodule
`default_nettype wire

// ===== sv/thws_checker.sv =====
`default_nettype none
`include "task_heartbeat_watchdog_supervisor_defines.svh"
module thws_checker
  import thws_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata
);

  `THWS_ASSERT_NEXT_ALWAYS(a_reset_empties, rst, !m_tvalid)
  `THWS_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `THWS_ASSERT_NOW(a_alive_needs_check, m_tvalid && !m_tdata[51], !m_tdata[52])
  `THWS_ASSERT_NOW(a_value_needs_write, m_tvalid && !m_tdata[1], m_tdata[33:2] == 32'd0)
  `THWS_ASSERT_NOW(a_check_refresh_alive, m_tvalid && m_tdata[51], m_tdata[0] == m_tdata[52])

endmodule

bind task_heartbeat_watchdog_supervisor thws_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== bench/tb_task_heartbeat_watchdog_supervisor.sv =====
`default_nettype none
module tb_task_heartbeat_watchdog_supervisor;
  import thws_pkg::*;

  localparam int TASKS = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 250;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  task_heartbeat_watchdog_supervisor #(.TASKS(TASKS)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // supervisor state mirror
  cfg_t cfg = '{GRACE_RESET, PERIOD_RESET, STABLE_RESET, WARN_RESET};
  logic [TASKS-1:0] beat_seen = '0;
  logic grace_on = 1'b1;
  logic [7:0] tick_cnt = '0;
  logic [15:0] good_run = '0;
  logic counter_cleared = 1'b0;
  logic [15:0] boot_cnt = '0;

  item_t event_queue[$];
  res_t expected_results[$];
  item_t offered;
  int outstanding = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit long_hold_done = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;

  function automatic res_t supervise_step(item_t it);
    res_t r;
    logic [15:0] cnt;
    r = '0;
    case (it.operation)
      OP_BOOT: begin
        cnt = 16'd1;
        if (it.backup_word[31:16] == MAGIC_HI) begin
          cnt = (it.backup_word[15:0] == COUNT_MAX) ? COUNT_MAX : it.backup_word[15:0] + 16'd1;
        end
        r.backup_write = 1'b1;
        r.backup_value = {MAGIC_HI, cnt};
        boot_cnt = cnt;
        grace_on = 1'b1;
        tick_cnt = '0;
        beat_seen = '0;
        good_run = '0;
        counter_cleared = 1'b0;
      end
      OP_BEAT: begin
        if (it.task_id < TASKS) beat_seen[it.task_id] = 1'b1;
      end
      OP_TICK: begin
        tick_cnt = tick_cnt + 8'd1;
        if (grace_on) begin
          r.refresh = 1'b1;
          if (tick_cnt >= cfg.grace_ticks) begin
            grace_on = 1'b0;
            tick_cnt = '0;
            beat_seen = '0;
          end
        end else if (tick_cnt >= cfg.check_period_ticks) begin
          tick_cnt = '0;
          r.check_done = 1'b1;
          r.tasks_ok = &beat_seen;
          beat_seen = '0;
          if (r.tasks_ok) begin
            r.refresh = 1'b1;
            if (!counter_cleared) begin
              if (good_run != COUNT_MAX) good_run = good_run + 16'd1;
              if (good_run >= cfg.stable_checks) begin
                r.backup_write = 1'b1;
                r.backup_value = {MAGIC_HI, 16'h0000};
                counter_cleared = 1'b1;
              end
            end
          end else begin
            good_run = '0;
          end
        end
      end
      default: ;
    endcase
    r.boot_count = boot_cnt;
    r.repeated_reset = (boot_cnt >= cfg.warn_boot_count);
    return r;
  endfunction

  task automatic flag_field(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at result %0d, %s: expected %0h, got %0h",
               results_seen, what, want, got);
    end
  endtask

  task automatic compare_result(res_t want, logic [M_TDATA_W-1:0] raw);
    res_t got;
    got = res_t'(raw[52:0]);
    if (got.refresh !== want.refresh) flag_field("refresh", want.refresh, got.refresh);
    if (got.backup_write !== want.backup_write)
      flag_field("backup_write", want.backup_write, got.backup_write);
    if (got.backup_value !== want.backup_value)
      flag_field("backup_value", want.backup_value, got.backup_value);
    if (got.boot_count !== want.boot_count)
      flag_field("boot_count", want.boot_count, got.boot_count);
    if (got.repeated_reset !== want.repeated_reset)
      flag_field("repeated_reset", want.repeated_reset, got.repeated_reset);
    if (got.check_done !== want.check_done)
      flag_field("check_done", want.check_done, got.check_done);
    if (got.tasks_ok !== want.tasks_ok)
      flag_field("tasks_ok", want.tasks_ok, got.tasks_ok);
    if (raw[M_TDATA_W-1:53] !== '0) flag_field("padding", 0, raw[M_TDATA_W-1:53]);
  endtask

  // input side
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) expected_results.push_back(supervise_step(offered));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          gap_left = $urandom_range(0, 14);
          s_tvalid <= 1'b0;
        end else if (event_queue.size() != 0) begin
          offered = event_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {{(S_TDATA_W-37){1'b0}}, offered.backup_word, offered.task_id};
          s_tuser <= offered.operation;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %0h", m_tdata);
        end else begin
          compare_result(expected_results.pop_front(), m_tdata);
          outstanding--;
        end
      end
      // one long hold so the block backs up into its input
      if (!long_hold_done && results_seen >= 150) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 14);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_item(logic [1:0] op, logic [4:0] id, logic [31:0] word);
    item_t it;
    it.operation = op;
    it.task_id = id;
    it.backup_word = word;
    outstanding++;
    event_queue.push_back(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GRACE_TICKS:   cfg.grace_ticks = value[7:0];
      REG_CHECK_PERIOD:  cfg.check_period_ticks = value[7:0];
      REG_STABLE_CHECKS: cfg.stable_checks = value[15:0];
      REG_WARN_BOOT:     cfg.warn_boot_count = value[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(int grace, int period, int stable, int warn);
    wait_idle();
    write_reg(REG_GRACE_TICKS, grace);
    write_reg(REG_CHECK_PERIOD, period);
    write_reg(REG_STABLE_CHECKS, stable);
    write_reg(REG_WARN_BOOT, warn);
  endtask

  function automatic logic [31:0] boot_word();
    case ($urandom_range(0, 4))
      0: return {MAGIC_HI, 16'($urandom_range(0, 8))};
      1: return {MAGIC_HI, COUNT_MAX};
      2: return {MAGIC_HI, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // mostly whole check periods with every task beating, plus noise
  task automatic fill_events(int n);
    int queued;
    int pick;
    int first;
    int period;
    queued = 0;
    period = (cfg.check_period_ticks == 0) ? 1 : cfg.check_period_ticks;
    while (queued < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        queue_item(OP_BOOT, 5'($urandom), boot_word());
        queued++;
      end else if (pick < 80) begin
        first = $urandom_range(0, TASKS - 1);
        for (int k = 0; k < TASKS; k++) begin
          if ($urandom_range(0, 24) != 0) begin
            queue_item(OP_BEAT, 5'((first + k) % TASKS), $urandom);
            queued++;
          end
        end
        for (int k = 0; k < period; k++) begin
          queue_item(OP_TICK, 5'($urandom), $urandom);
          queued++;
        end
      end else if (pick < 90) begin
        queue_item(OP_BEAT, 5'($urandom_range(0, 31)), $urandom);
        queued++;
      end else if (pick < 97) begin
        queue_item(OP_TICK, 5'($urandom), $urandom);
        queued++;
      end else begin
        queue_item(OP_UNKNOWN, 5'($urandom), $urandom);
        queued++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: short grace, period of two, first good check clears
    set_config(2, 2, 1, 2);
    queue_item(OP_TICK, 5'd0, 32'h0);
    queue_item(OP_BEAT, 5'd0, 32'h0);
    queue_item(OP_UNKNOWN, 5'd31, 32'hFFFF_FFFF);
    queue_item(OP_BOOT, 5'd0, {MAGIC_HI, COUNT_MAX});
    queue_item(OP_BOOT, 5'd31, {MAGIC_HI, 16'h0000});
    queue_item(OP_BOOT, 5'd0, 32'hFFFF_FFFF);
    queue_item(OP_BOOT, 5'd0, 32'h0000_0000);
    queue_item(OP_BOOT, 5'd0, {MAGIC_HI, 16'h0004});
    queue_item(OP_BEAT, 5'd31, 32'h0);
    queue_item(OP_BEAT, 5'(TASKS), 32'h0);
    queue_item(OP_TICK, 5'd0, 32'h0);
    queue_item(OP_TICK, 5'd0, 32'h0);
    for (int t = 0; t < TASKS; t++) queue_item(OP_BEAT, 5'(t), 32'h0);
    queue_item(OP_TICK, 5'd0, 32'h0);
    queue_item(OP_TICK, 5'd0, 32'h0);
    queue_item(OP_TICK, 5'd0, 32'h0);
    queue_item(OP_TICK, 5'd0, 32'h0);

    set_config(GRACE_RESET, PERIOD_RESET, STABLE_RESET, WARN_RESET);
    fill_events(350);
    set_config(1, 1, 1, 1);
    fill_events(300);
    set_config(255, 255, 65535, 65535);
    fill_events(250);
    set_config(0, 0, 0, 0);
    fill_events(300);
    set_config($urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(1, 8),
               $urandom_range(1, 10));
    fill_events(300);
    set_config(4, 3, 2, 3);
    calm = 1'b1;
    fill_events(300);

    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
